// ----- design/irs_pkg.sv -----
// Shared types and constants for the instruction ROM sequencer.
// Holds the input and result word layouts, operation and register codes.
// No dependencies; every other design file imports this package.
package irs_pkg;

    // Field widths.
    localparam int PC_W    = 17;
    localparam int INSTR_W = 13;
    localparam int EXT_W   = 16;
    localparam int WADDR_W = 10;

    // Instruction bit positions and the preset shift.
    localparam int COND_BIT     = 11;
    localparam int BRANCH_BIT   = 12;
    localparam int PRESET_SHIFT = 3;

    // Reset values of the counter and of the window registers.
    localparam logic [PC_W-1:0] PC_RESET        = 17'h10000;
    localparam logic [PC_W-1:0] ROM_START_RESET = 17'd0;
    localparam logic [PC_W-1:0] ROM_END_RESET   = 17'd1024;

    // Operation codes carried in the input word.
    typedef enum logic [1:0] {
        OP_OUTPUT = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_LOAD   = 2'd2
    } irs_op_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_ROM_START = 1'b0,
        REG_ROM_END   = 1'b1
    } irs_reg_t;

    // One input word.
    typedef struct packed {
        logic [1:0]         operation;
        logic               hold_line;
        logic               cond_line;
        logic [INSTR_W-1:0] bus_irg;
        logic               sample_preg;
        logic [EXT_W-1:0]   bus_ext;
        logic [WADDR_W-1:0] load_addr;
        logic [INSTR_W-1:0] load_data;
    } irs_in_t;

    // One result word.
    typedef struct packed {
        logic               drive;
        logic [INSTR_W-1:0] irg_out;
        logic [WADDR_W-1:0] rom_addr;
    } irs_out_t;

    // Per-stage control bundle that travels down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_out;
        logic is_load;
    } irs_ctl_t;

    // ROM write request carried alongside the control bundle.
    typedef struct packed {
        logic [WADDR_W-1:0] addr;
        logic [INSTR_W-1:0] data;
    } irs_load_t;

endpackage

// ----- design/irs_pc.sv -----
// Program counter stage: sample latches, counter update and stage 1 register.
// Depends on irs_pkg.
module irs_pc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              accept,
    input  irs_pkg::irs_in_t                  in_data,
    output irs_pkg::irs_ctl_t                 s1_ctl,
    output logic [irs_pkg::PC_W-1:0]          s1_pc,
    output irs_pkg::irs_load_t                s1_load
);
    import irs_pkg::*;

    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    logic [INSTR_W-1:0] instr_reg;
    logic [EXT_W-1:0]   ext_reg;
    logic               preset_reg;
    irs_ctl_t           s1_ctl_reg;
    irs_ctl_t           s1_ctl_next;
    logic [PC_W-1:0]    s1_pc_reg;
    irs_load_t          s1_load_reg;
    logic [PC_W-1:0]    offset;
    logic [EXT_W-1:0]   preset_val;

    // Next counter value in priority order: hold, preset, taken branch, step.
    always_comb
    begin
        offset     = PC_W'(instr_reg[WADDR_W:1]);
        preset_val = ext_reg >> PRESET_SHIFT;
        if (in_data.hold_line)
        begin
            pc_next = pc_reg;
        end
        else if (preset_reg)
        begin
            pc_next = PC_W'(preset_val);
        end
        else if (instr_reg[BRANCH_BIT] && (in_data.cond_line == instr_reg[COND_BIT]))
        begin
            pc_next = instr_reg[0] ? (pc_reg - offset) : (pc_reg + offset);
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // Only output and load words travel further down the pipeline.
    always_comb
    begin
        s1_ctl_next.valid   = accept && ((in_data.operation == OP_OUTPUT) ||
                                         (in_data.operation == OP_LOAD));
        s1_ctl_next.is_out  = (in_data.operation == OP_OUTPUT);
        s1_ctl_next.is_load = (in_data.operation == OP_LOAD);
    end

    // Architectural state and stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= PC_RESET;
            instr_reg  <= '0;
            ext_reg    <= '0;
            preset_reg <= 1'b0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_ctl_reg <= s1_ctl_next;
            end
            if (accept)
            begin
                case (in_data.operation)
                    OP_OUTPUT:
                    begin
                        pc_reg <= pc_next;
                    end
                    OP_SAMPLE:
                    begin
                        instr_reg  <= in_data.bus_irg;
                        ext_reg    <= in_data.bus_ext;
                        preset_reg <= in_data.sample_preg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pc_reg        <= pc_next;
            s1_load_reg.addr <= in_data.load_addr;
            s1_load_reg.data <= in_data.load_data;
        end
    end

    assign s1_ctl  = s1_ctl_reg;
    assign s1_pc   = s1_pc_reg;
    assign s1_load = s1_load_reg;

    // A held output word leaves the counter where it was.
    a_hold_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_data.operation == OP_OUTPUT) && in_data.hold_line
        |=> pc_reg == $past(pc_reg))
        else $error("counter moved on a held output word");

    // The stage register holds while the pipeline is stalled.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> s1_ctl_reg == $past(s1_ctl_reg))
        else $error("stage 1 changed during a stall");

endmodule

// ----- design/irs_addr.sv -----
// Address stages: window check, offset from start and reduction modulo the ROM depth.
// The reduction uses a reciprocal multiply in one stage and a back-multiply in the next.
// Depends on irs_pkg.
module irs_addr #(
    parameter int ROM_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic [irs_pkg::PC_W-1:0]          rom_start,
    input  logic [irs_pkg::PC_W-1:0]          rom_end,
    input  irs_pkg::irs_ctl_t                 s1_ctl,
    input  logic [irs_pkg::PC_W-1:0]          s1_pc,
    input  irs_pkg::irs_load_t                s1_load,
    output irs_pkg::irs_ctl_t                 s3_ctl,
    output logic                              s3_win,
    output logic [$clog2(ROM_DEPTH)-1:0]      s3_idx,
    output irs_pkg::irs_load_t                s3_load
);
    import irs_pkg::*;

    localparam int AW = $clog2(ROM_DEPTH);
    localparam int SH = PC_W + AW;
    localparam int RW = PC_W + 1;
    localparam int PW = PC_W + RW;
    localparam int QW = PC_W - AW + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(ROM_DEPTH) - 64'd1) / 64'(ROM_DEPTH);
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

    irs_ctl_t        s2_ctl_reg;
    logic [PC_W-1:0] s2_diff_reg;
    logic            s2_win_reg;
    irs_load_t       s2_load_reg;
    irs_ctl_t        s3_ctl_reg;
    logic [QW-1:0]   s3_q_reg;
    logic [PC_W-1:0] s3_diff_reg;
    logic            s3_win_reg;
    irs_load_t       s3_load_reg;
    logic [PW-1:0]   prod;
    logic [PC_W-1:0] qd;
    logic [PC_W-1:0] rem;

    // Quotient estimate, exact for every counter value.
    assign prod = PW'(s2_diff_reg) * PW'(RECIP);

    // Remainder from the registered quotient.
    assign qd  = PC_W'(PC_W'(s3_q_reg) * PC_W'(ROM_DEPTH));
    assign rem = s3_diff_reg - qd;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= s1_ctl;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_diff_reg <= s1_pc - rom_start;
            s2_win_reg  <= (s1_pc >= rom_start) && (s1_pc < rom_end);
            s2_load_reg <= s1_load;
            s3_q_reg    <= prod[SH +: QW];
            s3_diff_reg <= s2_diff_reg;
            s3_win_reg  <= s2_win_reg;
            s3_load_reg <= s2_load_reg;
        end
    end

    assign s3_ctl  = s3_ctl_reg;
    assign s3_win  = s3_win_reg;
    assign s3_idx  = rem[AW-1:0];
    assign s3_load = s3_load_reg;

    // The quotient never overshoots the offset.
    a_q_low: assert property (@(posedge clk) disable iff (!rst_n)
        s3_ctl_reg.valid && s3_ctl_reg.is_out |-> qd <= s3_diff_reg)
        else $error("quotient estimate too large");

    // The quotient never undershoots: the remainder stays below the depth.
    a_q_high: assert property (@(posedge clk) disable iff (!rst_n)
        s3_ctl_reg.valid && s3_ctl_reg.is_out |-> rem < PC_W'(ROM_DEPTH))
        else $error("quotient estimate too small");

endmodule

// ----- design/irs_rom.sv -----
// Instruction memory with registered read, and the result register.
// Loads and reads pass through the same stage, so they stay in order.
// Depends on irs_pkg.
module irs_rom #(
    parameter int ROM_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  irs_pkg::irs_ctl_t                 s3_ctl,
    input  logic                              s3_win,
    input  logic [$clog2(ROM_DEPTH)-1:0]      s3_idx,
    input  irs_pkg::irs_load_t                s3_load,
    output logic                              out_valid,
    output irs_pkg::irs_out_t                 out_data
);
    import irs_pkg::*;

    localparam int AW = $clog2(ROM_DEPTH);
    localparam int XW = ((AW > WADDR_W) ? AW : WADDR_W) + 1;

    logic [INSTR_W-1:0] mem [ROM_DEPTH];
    logic [INSTR_W-1:0] rd_reg;
    logic               out_valid_reg;
    logic               win_reg;
    logic [WADDR_W-1:0] addr_reg;
    logic [XW-1:0]      load_ext;
    logic [XW-1:0]      idx_ext;
    logic               load_ok;

    // Loads beyond the memory are dropped.
    assign load_ext = XW'(s3_load.addr);
    assign idx_ext  = XW'(s3_idx);
    assign load_ok  = load_ext < XW'(ROM_DEPTH);

    // Memory port: one write or one read per word.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s3_ctl.valid && s3_ctl.is_load && load_ok)
            begin
                mem[load_ext[AW-1:0]] <= s3_load.data;
            end
            if (s3_ctl.valid && s3_ctl.is_out)
            begin
                rd_reg <= mem[s3_idx];
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_ctl.valid && s3_ctl.is_out;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg  <= s3_win;
            addr_reg <= idx_ext[WADDR_W-1:0];
        end
    end

    // Outside the window every field reads zero.
    assign out_valid         = out_valid_reg;
    assign out_data.drive    = win_reg;
    assign out_data.irg_out  = win_reg ? rd_reg : '0;
    assign out_data.rom_addr = win_reg ? addr_reg : '0;

endmodule

// ----- design/instruction_rom_sequencer_top.sv -----
// Top level of the instruction ROM sequencer: configuration registers,
// handshake control and the three pipeline parts. Depends on irs_pkg,
// irs_pc, irs_addr and irs_rom.
//
// The sequencer takes one input word per clock cycle unless in_stall is
// high. An output-phase word yields one result word at the pipeline's end;
// sample and load words yield none. The counter update loops within the
// first stage and sets the rate; the window check, the reduction of the
// offset modulo the ROM depth and the registered memory read follow in
// three more stages. Input stall is raised only while a result waits and
// the output side stalls. The window registers may be written only while
// the block is idle. No clearing pass is needed after reset.
module instruction_rom_sequencer_top #(
    parameter int ROM_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  irs_pkg::irs_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output irs_pkg::irs_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [irs_pkg::PC_W-1:0]          cfg_data
);
    import irs_pkg::*;

    localparam int AW = $clog2(ROM_DEPTH);

    logic            adv;
    logic            accept;
    logic [PC_W-1:0] rom_start_reg;
    logic [PC_W-1:0] rom_end_reg;
    irs_ctl_t        s1_ctl;
    logic [PC_W-1:0] s1_pc;
    irs_load_t       s1_load;
    irs_ctl_t        s3_ctl;
    logic            s3_win;
    logic [AW-1:0]   s3_idx;
    irs_load_t       s3_load;

    // The whole pipeline moves unless a finished result is held back.
    assign in_stall  = out_valid && out_stall;
    assign adv       = !in_stall;
    assign accept    = in_valid && adv;
    assign cfg_ready = 1'b1;

    // Window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_start_reg <= ROM_START_RESET;
            rom_end_reg   <= ROM_END_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROM_START: rom_start_reg <= cfg_data;
                REG_ROM_END:   rom_end_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    irs_pc u_pc (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .accept  (accept),
        .in_data (in_data),
        .s1_ctl  (s1_ctl),
        .s1_pc   (s1_pc),
        .s1_load (s1_load)
    );

    irs_addr #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rom_start (rom_start_reg),
        .rom_end   (rom_end_reg),
        .s1_ctl    (s1_ctl),
        .s1_pc     (s1_pc),
        .s1_load   (s1_load),
        .s3_ctl    (s3_ctl),
        .s3_win    (s3_win),
        .s3_idx    (s3_idx),
        .s3_load   (s3_load)
    );

    irs_rom #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s3_ctl    (s3_ctl),
        .s3_win    (s3_win),
        .s3_idx    (s3_idx),
        .s3_load   (s3_load),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for instruction_rom_sequencer_top.
// Uses the types of irs_pkg and predicts each result word in its own model or takes it from the directed table.
// Drives a directed table first, then random bus phases under several windows.
`timescale 1ns / 100ps

module tb_top;

    import irs_pkg::*;

    localparam int ROM_WORDS      = 1024;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_OFF_LEN   = 100;
    localparam int PHASE_ITEMS    = 130;
    localparam int PRESSURE_ITEMS = 60;

    // Operation code that the block has no use for.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result word of an output phase outside the window.
    localparam irs_out_t OFF_WORD = '0;

    // Counter and latches of the sequencer.
    typedef struct packed {
        logic [PC_W-1:0]    pc;
        logic [INSTR_W-1:0] instr;
        logic [EXT_W-1:0]   ext;
        logic               preset;
    } seq_regs_t;

    // One input word, with its result typed in where it is known by hand.
    typedef struct packed {
        irs_in_t  word;
        logic     known;
        irs_out_t want;
    } row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    irs_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    irs_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_index = 1'b0;
    logic [PC_W-1:0] cfg_data = '0;

    // Sequencer state seen by the checker and by the stimulus side.
    seq_regs_t          seq_regs;
    seq_regs_t          plan_regs;
    logic [PC_W-1:0]    win_start;
    logic [PC_W-1:0]    win_end;
    logic [INSTR_W-1:0] rom_image [ROM_WORDS];
    logic [ROM_WORDS-1:0] rom_filled = '0;

    irs_out_t due_words [$];
    row_t     typed_rows [$];
    row_t     directed_rows [$];

    int   fail_count = 0;
    int   items_sent = 0;
    logic calm = 1'b0;
    logic hold_off_req = 1'b0;

    instruction_rom_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Counter update of an output phase: hold, then preset, then branch, else step.
    function automatic logic [PC_W-1:0] next_count(seq_regs_t s, logic hold, logic cond);
        logic [WADDR_W-1:0] jump;
        jump = s.instr[10:1];
        if (hold)
            return s.pc;
        if (s.preset)
            return PC_W'(s.ext >> PRESET_SHIFT);
        if (s.instr[BRANCH_BIT] && cond == s.instr[COND_BIT])
            return s.instr[0] ? s.pc - PC_W'(jump) : s.pc + PC_W'(jump);
        return s.pc + PC_W'(1);
    endfunction

    function automatic seq_regs_t advance(seq_regs_t s, irs_in_t w);
        seq_regs_t n;
        n = s;
        if (w.operation == OP_OUTPUT)
            n.pc = next_count(s, w.hold_line, w.cond_line);
        else if (w.operation == OP_SAMPLE)
        begin
            n.instr  = w.bus_irg;
            n.preset = w.sample_preg;
            n.ext    = w.bus_ext;
        end
        return n;
    endfunction

    function automatic logic in_window(logic [PC_W-1:0] pc);
        return pc >= win_start && pc < win_end;
    endfunction

    // ROM word read for a counter inside the window, wrapped to the ROM depth.
    function automatic logic [WADDR_W-1:0] word_slot(logic [PC_W-1:0] pc);
        logic [PC_W-1:0] diff;
        diff = pc - win_start;
        diff = PC_W'(diff % ROM_WORDS);
        return diff[WADDR_W-1:0];
    endfunction

    function automatic irs_out_t served_word(logic [PC_W-1:0] pc);
        irs_out_t r;
        logic [WADDR_W-1:0] slot;
        r = '0;
        if (in_window(pc))
        begin
            slot       = word_slot(pc);
            r.drive    = 1'b1;
            r.irg_out  = rom_image[slot];
            r.rom_addr = slot;
        end
        return r;
    endfunction

    // Update the expected state for each accepted input word.
    task automatic accept_word(irs_in_t w);
        row_t tag;
        tag = typed_rows.pop_front();
        seq_regs = advance(seq_regs, w);
        if (w.operation == OP_LOAD)
            rom_image[w.load_addr] = w.load_data;
        else if (w.operation == OP_OUTPUT)
            due_words.push_back(tag.known ? tag.want : served_word(seq_regs.pc));
    endtask

    task automatic compare_word(irs_out_t got);
        irs_out_t want;
        if (due_words.size() == 0)
        begin
            $error("unexpected result word: drive %0d irg_out %h rom_addr %0d",
                   got.drive, got.irg_out, got.rom_addr);
            fail_count++;
            return;
        end
        want = due_words.pop_front();
        if (got.drive !== want.drive)
        begin
            $error("drive: expected %0d, got %0d", want.drive, got.drive);
            fail_count++;
        end
        if (got.irg_out !== want.irg_out)
        begin
            $error("irg_out: expected %h, got %h", want.irg_out, got.irg_out);
            fail_count++;
        end
        if (got.rom_addr !== want.rom_addr)
        begin
            $error("rom_addr: expected %0d, got %0d", want.rom_addr, got.rom_addr);
            fail_count++;
        end
    endtask

    // Watch both channels at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                accept_word(in_data);
            if (out_valid && !out_stall)
                compare_word(out_data);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pause_len()) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Offer one word and wait until the block takes it.
    task automatic put_word(irs_in_t w, logic known, irs_out_t want);
        int gap;
        row_t tag;
        tag.word  = w;
        tag.known = known;
        tag.want  = want;
        typed_rows.push_back(tag);
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        plan_regs = advance(plan_regs, w);
        if (w.operation == OP_LOAD)
            rom_filled[w.load_addr] = 1'b1;
        if (w.operation != OP_UNUSED)
            items_sent++;
    endtask

    function automatic irs_in_t rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(irs_in_t)-1:0];
    endfunction

    // Any output phase that would read a ROM word never written gets a load first.
    task automatic issue(irs_in_t w, logic known, irs_out_t want);
        logic [PC_W-1:0] pc_next;
        logic [WADDR_W-1:0] slot;
        irs_in_t filler;
        if (w.operation == OP_OUTPUT)
        begin
            pc_next = next_count(plan_regs, w.hold_line, w.cond_line);
            slot = word_slot(pc_next);
            if (in_window(pc_next) && !rom_filled[slot])
            begin
                filler = rand_word();
                filler.operation = OP_LOAD;
                filler.load_addr = slot;
                put_word(filler, 1'b0, OFF_WORD);
            end
        end
        put_word(w, known, want);
    endtask

    // Preset target biased into the current window where the preset can reach it.
    function automatic logic [INSTR_W-1:0] aim_count();
        logic [31:0] r;
        int hi;
        if (win_start < win_end && win_start < 8192)
        begin
            hi = win_end + 2;
            if (hi > 8191)
                hi = 8191;
            r = $urandom_range(hi, win_start);
        end
        else
            r = $urandom_range(0, 8191);
        return r[INSTR_W-1:0];
    endfunction

    function automatic irs_in_t output_word();
        irs_in_t w;
        w = rand_word();
        w.operation = OP_OUTPUT;
        w.hold_line = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    function automatic irs_in_t sample_word();
        irs_in_t w;
        w = rand_word();
        w.operation   = OP_SAMPLE;
        w.sample_preg = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 1)
            w.bus_ext = {aim_count(), w.bus_ext[2:0]};
        return w;
    endfunction

    // One random stretch: sample then output, lone outputs, loads, noise or longer runs.
    task automatic random_burst();
        irs_in_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            issue(sample_word(), 1'b0, OFF_WORD);
            issue(output_word(), 1'b0, OFF_WORD);
        end
        else if (pick < 70)
            issue(output_word(), 1'b0, OFF_WORD);
        else if (pick < 84)
        begin
            w = rand_word();
            w.operation = OP_LOAD;
            issue(w, 1'b0, OFF_WORD);
        end
        else if (pick < 90)
        begin
            w = rand_word();
            w.operation = OP_UNUSED;
            issue(w, 1'b0, OFF_WORD);
        end
        else if (pick < 96)
        begin
            issue(sample_word(), 1'b0, OFF_WORD);
            issue(sample_word(), 1'b0, OFF_WORD);
            issue(output_word(), 1'b0, OFF_WORD);
        end
        else
        begin
            repeat ($urandom_range(2, 6)) issue(output_word(), 1'b0, OFF_WORD);
        end
    endtask

    task automatic run_random(int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
            random_burst();
    endtask

    // Wait until every expected word is in, then let the pipeline drain.
    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (due_words.size() != 0)
        begin
            $error("%0d result words never arrived", due_words.size());
            fail_count++;
            due_words.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(irs_reg_t idx, logic [PC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_ROM_START)
            win_start = value;
        else
            win_end = value;
    endtask

    task automatic set_window(logic [PC_W-1:0] lo, logic [PC_W-1:0] hi);
        settle();
        write_reg(REG_ROM_START, lo);
        write_reg(REG_ROM_END, hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic irs_in_t make_word(logic [1:0] op, logic hold, logic cond,
                                          logic [INSTR_W-1:0] irg, logic preg,
                                          logic [EXT_W-1:0] ext, logic [WADDR_W-1:0] laddr,
                                          logic [INSTR_W-1:0] ldata);
        irs_in_t w;
        w.operation   = op;
        w.hold_line   = hold;
        w.cond_line   = cond;
        w.bus_irg     = irg;
        w.sample_preg = preg;
        w.bus_ext     = ext;
        w.load_addr   = laddr;
        w.load_data   = ldata;
        return w;
    endfunction

    task automatic add_row(irs_in_t w, logic known, irs_out_t want);
        row_t r;
        r.word  = w;
        r.known = known;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        seq_regs  = '{pc: PC_RESET, default: '0};
        plan_regs = '{pc: PC_RESET, default: '0};
        win_start = ROM_START_RESET;
        win_end   = ROM_END_RESET;

        // Counter outside the window after reset, hold first.
        add_row(make_word(OP_OUTPUT, 1, 0, 0, 0, 0, 0, 0), 1, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 1, OFF_WORD);
        add_row(make_word(OP_LOAD, 0, 0, 0, 0, 0, 10'd0, 13'h1FFF), 0, OFF_WORD);
        add_row(make_word(OP_LOAD, 0, 0, 0, 0, 0, 10'd1023, 13'h0000), 0, OFF_WORD);
        add_row(make_word(OP_LOAD, 0, 0, 0, 0, 0, 10'd5, 13'h0AAA), 0, OFF_WORD);
        // Preset to zero, then plain advance.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h0000, 1, 16'h0000, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 13'h1FFF, 10'd0});
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h0000, 0, 16'hFFFF, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 0, OFF_WORD);
        // Forward branch taken, then not taken.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h1808, 0, 16'h0000, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 1, 0, 0, 0, 0, 0), 1, '{1'b1, 13'h0AAA, 10'd5});
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 0, OFF_WORD);
        // Largest backward branch wraps below zero.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h1FFF, 0, 16'h0000, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 1, 0, 0, 0, 0, 0), 1, OFF_WORD);
        // Largest preset; hold wins over it.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h0000, 1, 16'hFFFF, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 1, 1, 0, 0, 0, 0, 0), 1, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 1, OFF_WORD);
        // Last word of the window, then one past it.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h0000, 1, 16'h1FF8, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 13'h0000, 10'd1023});
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h0000, 0, 16'h0000, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0), 1, OFF_WORD);
        // Unused operation with every field at its top value.
        add_row(make_word(OP_UNUSED, 1, 1, 13'h1FFF, 1, 16'hFFFF, 10'h3FF, 13'h1FFF),
                0, OFF_WORD);
        // Preset wins over a branch whose condition matches.
        add_row(make_word(OP_SAMPLE, 0, 0, 13'h1FFF, 1, 16'h0028, 0, 0), 0, OFF_WORD);
        add_row(make_word(OP_OUTPUT, 0, 1, 0, 0, 0, 0, 0), 1, '{1'b1, 13'h0AAA, 10'd5});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].word, directed_rows[i].known, directed_rows[i].want);

        run_random(PHASE_ITEMS);

        // Window wider than the ROM, so reads wrap around it.
        set_window(17'd100, 17'd5000);
        run_random(PHASE_ITEMS);

        // Widest window; the output side holds off while the input keeps coming.
        set_window(17'd0, 17'h1FFFF);
        calm = 1'b1;
        hold_off_req = 1'b1;
        repeat (PRESSURE_ITEMS) issue(output_word(), 1'b0, OFF_WORD);
        calm = 1'b0;
        run_random(PHASE_ITEMS);

        // Inverted window: nothing is ever driven.
        set_window(17'h1FFFF, 17'd0);
        run_random(PHASE_ITEMS);

        // Back-to-back words with no stalls on either side.
        set_window(17'd2048, 17'd3072);
        calm = 1'b1;
        run_random(PHASE_ITEMS);
        calm = 1'b0;

        // Top of the counter range, reached only by wrapping branches.
        set_window(17'd130000, 17'h1FFFF);
        run_random(PHASE_ITEMS);

        // Empty window.
        set_window(17'd4000, 17'd4000);
        run_random(PHASE_ITEMS / 2);

        set_window(ROM_START_RESET, ROM_END_RESET);
        run_random(PHASE_ITEMS);

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/irs_pkg.sv
design/irs_pc.sv
design/irs_addr.sv
design/irs_rom.sv
design/instruction_rom_sequencer_top.sv
test/tb_top.sv
